### design/sddc_pkg.sv
package sddc_pkg;

    // Step directions, also the codes held in the change list
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    localparam int KEPT_CHANGES    = 4;
    localparam int CHANGE_IDX_BITS = $clog2(KEPT_CHANGES);
    localparam int JOB_COORD_BITS  = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] COUNT_MAX = 4'd15;
    localparam logic [3:0] NO_MATCH  = 4'd10;

    // Configuration register indexes
    localparam logic REG_SMOOTHING = 1'b0;
    localparam logic REG_ZERO_SIX  = 1'b1;

    typedef dir_t [KEPT_CHANGES-1:0] changes_t;

    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        stroke_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0] digit_code;
        logic [3:0] change_total;
    } out_item_t;

    // One finished stroke waiting for classification
    typedef struct packed {
        changes_t                  changes;
        logic [3:0]                count;
        logic [JOB_COORD_BITS-1:0] dx;
        logic [JOB_COORD_BITS-1:0] dy;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Decision tree over the kept direction changes
    function automatic logic [3:0] classify(changes_t c, logic [3:0] count, logic six);
        logic [3:0] res;
        res = NO_MATCH;
        case (count)
            4'd1: res = 4'd1;
            4'd2: begin
                if ((c[0] == DIR_DOWN && c[1] != DIR_UP) ||
                    (c[0] == DIR_UP && c[1] == DIR_DOWN))
                    res = 4'd1;
                else if (c[0] == DIR_RIGHT && c[1] == DIR_DOWN)
                    res = 4'd7;
            end
            4'd3: begin
                if (c[0] == DIR_RIGHT) begin
                    if (c[1] == DIR_DOWN) begin
                        if (c[2] == DIR_RIGHT) res = 4'd2;
                        else if (c[2] == DIR_LEFT) res = 4'd7;
                    end else if (c[1] == DIR_UP && c[2] == DIR_DOWN) begin
                        res = 4'd1;
                    end
                end else if (c[0] == DIR_LEFT && c[1] == DIR_DOWN && c[2] == DIR_LEFT) begin
                    res = 4'd5;
                end else if (c[0] == DIR_UP && c[1] == DIR_LEFT && c[2] == DIR_DOWN) begin
                    res = 4'd7;
                end
            end
            4'd4: begin
                if (c[0] == DIR_UP && c[1] == DIR_RIGHT && c[2] == DIR_DOWN) begin
                    if (c[3] == DIR_RIGHT) res = 4'd2;
                    else if (c[3] == DIR_LEFT) res = 4'd7;
                end else if (c[0] == DIR_LEFT) begin
                    if (c[1] == DIR_UP && c[2] == DIR_RIGHT && c[3] == DIR_DOWN)
                        res = 4'd9;
                    else if (c[1] == DIR_RIGHT && c[2] == DIR_DOWN && c[3] == DIR_LEFT)
                        res = 4'd5;
                    else if (c[1] == DIR_DOWN && c[2] == DIR_LEFT && c[3] == DIR_UP)
                        res = 4'd0;
                end else if (c[0] == DIR_DOWN && c[1] == DIR_RIGHT && c[2] == DIR_UP) begin
                    if (c[3] == DIR_DOWN) res = 4'd4;
                    else if (c[3] == DIR_LEFT) res = six ? 4'd6 : 4'd0;
                end else if (c[0] == DIR_RIGHT) begin
                    if (c[1] == DIR_DOWN && c[2] == DIR_LEFT && c[3] == DIR_RIGHT)
                        res = 4'd2;
                    else if (c[1] == DIR_LEFT && c[2] == DIR_RIGHT && c[3] == DIR_LEFT)
                        res = 4'd3;
                end
            end
            default: res = NO_MATCH;
        endcase
        return res;
    endfunction

endpackage

### design/stroke_direction_digit_classifier_unit.sv
// Pen stroke digit classifier.
// Input channel (s_*): one stroke vertex per transaction; stroke_end marks the
// last vertex. A vertex is taken every cycle while the stroke queue has room.
// Output channel (m_*): one result per stroke, carrying the digit code
// (10 = no match) and the number of direction changes.
// The last vertex's job is written into the queue, then classified into the output register;
// one vertex per cycle sustained while the queue has room, set by the front update loop.
// The front smooths each vertex, classes the step and updates the change list;
// finished strokes wait in a 2-entry queue; the back runs the decision tree
// and holds the result in an output register.
// A stalled receiver stops the back end only; the front keeps accepting
// vertices until two finished strokes are queued behind the held result.
// Reset clears stroke state, queue and output valid, and sets smoothing off
// and the zero/six factor to 4. Registers are written over the APB port:
// 0x0 smoothing enable, 0x4 zero/six factor.
module stroke_direction_digit_classifier_unit
    import sddc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       smoothing_enable_reg;
    logic [3:0] zero_six_factor_reg;
    logic       reg_idx;
    logic       cfg_write;

    logic      push, pop;
    job_t      push_job, pop_job;
    q_status_t q_status;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothing_enable_reg <= 1'b0;
            zero_six_factor_reg  <= 4'd4;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SMOOTHING: smoothing_enable_reg <= pwdata[0];
                REG_ZERO_SIX:  zero_six_factor_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SMOOTHING: prdata = {31'd0, smoothing_enable_reg};
            REG_ZERO_SIX:  prdata = {28'd0, zero_six_factor_reg};
            default:       prdata = '0;
        endcase
    end

    sddc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .smoothing_enable (smoothing_enable_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload        (s_payload),
        .q_status         (q_status),
        .push             (push),
        .push_job         (push_job)
    );

    sddc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    sddc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .zero_six_factor (zero_six_factor_reg),
        .q_status        (q_status),
        .pop             (pop),
        .pop_job         (pop_job),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload)
    );

endmodule

### design/sddc_front.sv
module sddc_front
    import sddc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      smoothing_enable,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    input  q_status_t q_status,
    output logic      push,
    output job_t      push_job
);

    function automatic logic [COORD_BITS-1:0] abs_diff(logic [COORD_BITS-1:0] a,
                                                       logic [COORD_BITS-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic                  have_prior_reg;
    logic [COORD_BITS-1:0] prior_x_reg, prior_y_reg;
    logic [COORD_BITS-1:0] start_x_reg, start_y_reg;
    dir_t                  heading_reg;
    changes_t              list_reg;
    logic [3:0]            count_reg;

    logic                  accept;
    logic [COORD_BITS-1:0] x_raw, y_raw, x_new, y_new;
    logic [COORD_BITS-1:0] ax, ay, start_x_eff, start_y_eff;
    dir_t                  dir;
    logic                  is_change;
    changes_t              list_next;
    logic [3:0]            count_next;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // Smoothing, step direction and change-list update
    always_comb begin
        x_raw = COORD_BITS'(s_payload.pos_x);
        y_raw = COORD_BITS'(s_payload.pos_y);
        if (have_prior_reg && smoothing_enable) begin
            x_new = (prior_x_reg >> 1) + (prior_x_reg >> 2) + (x_raw >> 2);
            y_new = (prior_y_reg >> 1) + (prior_y_reg >> 2) + (y_raw >> 2);
        end else begin
            x_new = x_raw;
            y_new = y_raw;
        end
        ax = abs_diff(x_new, prior_x_reg);
        ay = abs_diff(y_new, prior_y_reg);
        if (ax >= ay)
            dir = (x_new >= prior_x_reg) ? DIR_RIGHT : DIR_LEFT;
        else
            dir = (y_new < prior_y_reg) ? DIR_UP : DIR_DOWN;

        is_change = have_prior_reg && ((count_reg == 4'd0) || (dir != heading_reg));
        list_next = list_reg;
        if (is_change && (count_reg < 4'(KEPT_CHANGES)))
            list_next[count_reg[CHANGE_IDX_BITS-1:0]] = dir;
        count_next = (is_change && (count_reg != COUNT_MAX)) ? count_reg + 4'd1 : count_reg;

        start_x_eff = have_prior_reg ? start_x_reg : x_raw;
        start_y_eff = have_prior_reg ? start_y_reg : y_raw;
    end

    // Finished stroke goes to the queue
    assign push             = accept && s_payload.stroke_end;
    assign push_job.changes = list_next;
    assign push_job.count   = count_next;
    assign push_job.dx      = JOB_COORD_BITS'(abs_diff(start_x_eff, x_new));
    assign push_job.dy      = JOB_COORD_BITS'(abs_diff(start_y_eff, y_new));

    // Stroke control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prior_reg <= 1'b0;
            heading_reg    <= DIR_RIGHT;
            count_reg      <= 4'd0;
        end else if (accept) begin
            if (s_payload.stroke_end) begin
                have_prior_reg <= 1'b0;
                heading_reg    <= DIR_RIGHT;
                count_reg      <= 4'd0;
            end else begin
                have_prior_reg <= 1'b1;
                count_reg      <= count_next;
                if (is_change)
                    heading_reg <= dir;
            end
        end
    end

    // Coordinates and change list
    always_ff @(posedge aclk) begin
        if (accept) begin
            prior_x_reg <= x_new;
            prior_y_reg <= y_new;
            list_reg    <= list_next;
            if (!have_prior_reg) begin
                start_x_reg <= x_raw;
                start_y_reg <= y_raw;
            end
        end
    end

endmodule

### design/sddc_queue.sv
module sddc_queue
    import sddc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t status
);

    job_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg;

    assign status.full  = (cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && status.empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !status.empty)
        else $error("pushed entry lost");
`endif

endmodule

### design/sddc_back.sv
module sddc_back
    import sddc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [3:0] zero_six_factor,
    input  q_status_t q_status,
    output logic      pop,
    input  job_t      pop_job,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int PROD_BITS = JOB_COORD_BITS + 4;

    logic                 m_valid_reg;
    out_item_t            m_payload_reg;
    logic [PROD_BITS-1:0] prod;
    logic                 six;
    out_item_t            result;

    assign pop = !q_status.empty && (!m_valid_reg || m_ready);

    // Zero/six ratio test and decision tree
    always_comb begin
        prod                = PROD_BITS'(zero_six_factor) * PROD_BITS'(pop_job.dx);
        six                 = PROD_BITS'(pop_job.dy) > prod;
        result.digit_code   = classify(pop_job.changes, pop_job.count, six);
        result.change_total = pop_job.count;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (pop)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pop)
            m_payload_reg <= result;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### test/tb_stroke_direction_digit_classifier_unit.sv
module tb_stroke_direction_digit_classifier_unit;
    import sddc_pkg::*;

    localparam int STALL_LIMIT     = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES    = 4;     // extra wait after the last awaited result is checked
    localparam int TAIL_CYCLES     = 10;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int PHASE_COUNT     = 5;
    localparam int VERTS_PER_PHASE = 120;

    typedef enum logic [1:0] {
        ROW_VERTEX,
        ROW_SET_SMOOTHING,
        ROW_SET_ZERO_SIX
    } row_kind_t;

    // One line of the directed script
    typedef struct packed {
        row_kind_t  kind;
        in_item_t   vertex;
        logic       fixed;
        out_item_t  want;
        logic [3:0] value;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_payload;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_payload;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and of the stroke state
    logic        cfg_smooth;
    logic [3:0]  cfg_ratio;
    logic        pen_down;
    logic [11:0] last_x, last_y;
    logic [11:0] origin_x, origin_y;
    dir_t        heading;
    dir_t        turns [KEPT_CHANGES];
    logic [3:0]  turn_count;

    out_item_t   awaited_results[$];
    row_t        script_rows[$];
    out_item_t   got;
    out_item_t   want;

    int          mismatches;
    int          strokes_checked;
    int          vertices_sent;
    int          register_writes;
    logic [10:0] digits_seen;
    bit          steady;        // no idling on either side
    int          phase_no;
    int          phase_sent;

    stroke_direction_digit_classifier_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [11:0] blend(input logic [11:0] prev, input logic [11:0] cur);
        logic [13:0] sum;
        sum = (prev >> 1) + (prev >> 2) + (cur >> 2);
        return sum[11:0];
    endfunction

    function automatic int clamp_coord(input int c);
        return (c < 0) ? 0 : ((c > 4095) ? 4095 : c);
    endfunction

    task automatic forget_stroke();
        pen_down   = 1'b0;
        last_x     = '0;
        last_y     = '0;
        origin_x   = '0;
        origin_y   = '0;
        heading    = DIR_RIGHT;
        turn_count = '0;
    endtask

    // Advance the predicted state by one vertex; on a final vertex give the result
    task automatic predict_vertex(input in_item_t v, output bit done, output out_item_t res);
        logic [11:0] x, y;
        logic [11:0] key;
        dir_t        step;
        int          ax, ay, span_x, span_y;
        x = v.pos_x;
        y = v.pos_y;
        if (!pen_down) begin
            origin_x = x;
            origin_y = y;
        end else begin
            if (cfg_smooth) begin
                x = blend(last_x, x);
                y = blend(last_y, y);
            end
            ax = (x >= last_x) ? int'(x) - int'(last_x) : int'(last_x) - int'(x);
            ay = (y >= last_y) ? int'(y) - int'(last_y) : int'(last_y) - int'(y);
            if (ax >= ay)
                step = (x >= last_x) ? DIR_RIGHT : DIR_LEFT;
            else
                step = (y < last_y) ? DIR_UP : DIR_DOWN;
            // run compression: only a new heading counts as a change
            if (turn_count == 0 || step != heading) begin
                if (turn_count < KEPT_CHANGES)
                    turns[turn_count[1:0]] = step;
                heading = step;
                if (turn_count != COUNT_MAX)
                    turn_count++;
            end
        end
        last_x   = x;
        last_y   = y;
        pen_down = 1'b1;
        done     = v.stroke_end;
        res      = '0;
        if (done) begin
            span_x = (origin_x >= x) ? int'(origin_x) - int'(x) : int'(x) - int'(origin_x);
            span_y = (origin_y >= y) ? int'(origin_y) - int'(y) : int'(y) - int'(origin_y);
            key = {turn_count, turns[0], turns[1], turns[2], turns[3]};
            // change-sequence lookup; unused slots are don't-care
            casez (key)
                {4'd1, 8'b????????},
                {4'd2, DIR_DOWN, DIR_RIGHT, 4'b????},
                {4'd2, DIR_DOWN, DIR_LEFT, 4'b????},
                {4'd2, DIR_DOWN, DIR_DOWN, 4'b????},
                {4'd2, DIR_UP, DIR_DOWN, 4'b????},
                {4'd3, DIR_RIGHT, DIR_UP, DIR_DOWN, 2'b??}:
                    res.digit_code = 4'd1;
                {4'd3, DIR_RIGHT, DIR_DOWN, DIR_RIGHT, 2'b??},
                {4'd4, DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_RIGHT},
                {4'd4, DIR_RIGHT, DIR_DOWN, DIR_LEFT, DIR_RIGHT}:
                    res.digit_code = 4'd2;
                {4'd4, DIR_RIGHT, DIR_LEFT, DIR_RIGHT, DIR_LEFT}:
                    res.digit_code = 4'd3;
                {4'd4, DIR_DOWN, DIR_RIGHT, DIR_UP, DIR_DOWN}:
                    res.digit_code = 4'd4;
                {4'd3, DIR_LEFT, DIR_DOWN, DIR_LEFT, 2'b??},
                {4'd4, DIR_LEFT, DIR_RIGHT, DIR_DOWN, DIR_LEFT}:
                    res.digit_code = 4'd5;
                {4'd2, DIR_RIGHT, DIR_DOWN, 4'b????},
                {4'd3, DIR_RIGHT, DIR_DOWN, DIR_LEFT, 2'b??},
                {4'd3, DIR_UP, DIR_LEFT, DIR_DOWN, 2'b??},
                {4'd4, DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT}:
                    res.digit_code = 4'd7;
                {4'd4, DIR_LEFT, DIR_UP, DIR_RIGHT, DIR_DOWN}:
                    res.digit_code = 4'd9;
                {4'd4, DIR_LEFT, DIR_DOWN, DIR_LEFT, DIR_UP}:
                    res.digit_code = 4'd0;
                // loop closed at the bottom: tall end displacement means six
                {4'd4, DIR_DOWN, DIR_RIGHT, DIR_UP, DIR_LEFT}:
                    res.digit_code = (span_y > int'(cfg_ratio) * span_x) ? 4'd6 : 4'd0;
                default:
                    res.digit_code = NO_MATCH;
            endcase
            res.change_total = turn_count;
            forget_stroke();
        end
    endtask

    // Offer one vertex, hold it until accepted, then record the expected result
    task automatic send_vertex(input in_item_t v, input bit fixed, input out_item_t fixed_res);
        bit        done;
        out_item_t res;
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= v;
        do @(posedge aclk); while (!s_ready);
        predict_vertex(v, done, res);
        if (fixed)
            res = fixed_res;
        if (done)
            awaited_results = {awaited_results, res};
        vertices_sent++;
        phase_sent++;
    endtask

    // Stop offering and let every outstanding stroke come out
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SMOOTHING)
            cfg_smooth = value[0];
        else
            cfg_ratio = value[3:0];
        register_writes++;
    endtask

    function automatic void add_vertex(input int x, input int y, input bit last);
        row_t r;
        r = '0;
        r.kind   = ROW_VERTEX;
        r.vertex = {12'(x), 12'(y), last};
        script_rows = {script_rows, r};
    endfunction

    function automatic void add_checked(input int x, input int y, input logic [3:0] digit,
                                        input logic [3:0] count);
        row_t r;
        r = '0;
        r.kind   = ROW_VERTEX;
        r.vertex = {12'(x), 12'(y), 1'b1};
        r.fixed  = 1'b1;
        r.want   = {digit, count};
        script_rows = {script_rows, r};
    endfunction

    function automatic void add_setting(input row_kind_t kind, input logic [3:0] value);
        row_t r;
        r = '0;
        r.kind  = kind;
        r.value = value;
        script_rows = {script_rows, r};
    endfunction

    // Random stroke: mostly a known digit shape or a random heading path, else a scribble
    task automatic send_random_stroke();
        in_item_t    v;
        in_item_t    pts[$];
        dir_t        path [6];
        logic [11:0] shape;
        int          path_len, pick, px, py, seg_len, jit;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            repeat ($urandom_range(1, 8)) begin
                v.pos_x      = $urandom_range(0, 4095);
                v.pos_y      = $urandom_range(0, 4095);
                v.stroke_end = 1'b0;
                pts = {pts, v};
            end
        end else begin
            if (pick < 70) begin
                case ($urandom_range(0, 17))
                    0:  shape = {4'd2, DIR_RIGHT, DIR_DOWN, 4'b0};
                    1:  shape = {4'd2, DIR_DOWN, DIR_LEFT, 4'b0};
                    2:  shape = {4'd2, DIR_UP, DIR_DOWN, 4'b0};
                    3:  shape = {4'd3, DIR_RIGHT, DIR_DOWN, DIR_RIGHT, 2'b0};
                    4:  shape = {4'd3, DIR_RIGHT, DIR_DOWN, DIR_LEFT, 2'b0};
                    5:  shape = {4'd3, DIR_RIGHT, DIR_UP, DIR_DOWN, 2'b0};
                    6:  shape = {4'd3, DIR_LEFT, DIR_DOWN, DIR_LEFT, 2'b0};
                    7:  shape = {4'd3, DIR_UP, DIR_LEFT, DIR_DOWN, 2'b0};
                    8:  shape = {4'd4, DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_RIGHT};
                    9:  shape = {4'd4, DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT};
                    10: shape = {4'd4, DIR_LEFT, DIR_UP, DIR_RIGHT, DIR_DOWN};
                    11: shape = {4'd4, DIR_LEFT, DIR_RIGHT, DIR_DOWN, DIR_LEFT};
                    12: shape = {4'd4, DIR_LEFT, DIR_DOWN, DIR_LEFT, DIR_UP};
                    13: shape = {4'd4, DIR_DOWN, DIR_RIGHT, DIR_UP, DIR_DOWN};
                    14: shape = {4'd4, DIR_RIGHT, DIR_DOWN, DIR_LEFT, DIR_RIGHT};
                    15: shape = {4'd4, DIR_RIGHT, DIR_LEFT, DIR_RIGHT, DIR_LEFT};
                    default: shape = {4'd4, DIR_DOWN, DIR_RIGHT, DIR_UP, DIR_LEFT};
                endcase
                path_len = int'(shape[11:8]);
                for (int i = 0; i < path_len; i++)
                    path[i] = dir_t'(shape[7 - 2*i -: 2]);
            end else begin
                path_len = $urandom_range(1, 6);
                path[0]  = dir_t'($urandom_range(0, 3));
                for (int i = 1; i < path_len; i++)
                    do path[i] = dir_t'($urandom_range(0, 3)); while (path[i] == path[i-1]);
            end
            px = $urandom_range(600, 3500);
            py = $urandom_range(600, 3500);
            v  = {12'(px), 12'(py), 1'b0};
            pts = {pts, v};
            for (int i = 0; i < path_len; i++) begin
                repeat ($urandom_range(1, 3)) begin
                    seg_len = $urandom_range(1, 200);
                    // an occasional exact diagonal exercises the tie rule
                    jit = ($urandom_range(0, 15) == 0) ? seg_len : $urandom_range(0, seg_len / 3);
                    if ($urandom_range(0, 1))
                        jit = -jit;
                    case (path[i])
                        DIR_RIGHT: begin px += seg_len; py += jit; end
                        DIR_LEFT:  begin px -= seg_len; py += jit; end
                        DIR_UP:    begin py -= seg_len; px += jit; end
                        default:   begin py += seg_len; px += jit; end
                    endcase
                    px = clamp_coord(px);
                    py = clamp_coord(py);
                    v  = {12'(px), 12'(py), 1'b0};
                    pts = {pts, v};
                end
            end
        end
        v = pts[pts.size() - 1];
        v.stroke_end = 1'b1;
        pts[pts.size() - 1] = v;
        foreach (pts[i])
            send_vertex(pts[i], 1'b0, '0);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = m_payload;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result digit %0d changes %0d",
                                          got.digit_code, got.change_total));
            end else begin
                want = awaited_results.pop_front();
                if (got.digit_code !== want.digit_code)
                    report_mismatch($sformatf("digit_code got %0d want %0d",
                                              got.digit_code, want.digit_code));
                if (got.change_total !== want.change_total)
                    report_mismatch($sformatf("change_total got %0d want %0d",
                                              got.change_total, want.change_total));
                if (want.digit_code <= NO_MATCH)
                    digits_seen[want.digit_code] = 1'b1;
                strokes_checked++;
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off in the second random phase
    initial begin : result_sink
        int  holdoff_left;
        bit  holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!holdoff_done && phase_no == 2 && phase_sent >= 20) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, awaited_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        row_t row;
        mismatches      = 0;
        strokes_checked = 0;
        vertices_sent   = 0;
        register_writes = 0;
        digits_seen     = '0;
        steady          = 1'b0;
        phase_no        = 0;
        phase_sent      = 0;
        cfg_smooth      = 1'b0;
        cfg_ratio       = 4'd4;
        foreach (turns[i])
            turns[i] = DIR_RIGHT;
        forget_stroke();

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script
        // lone vertex at the far corner: no change at all
        add_checked(4095, 4095, NO_MATCH, 4'd0);
        // one step across the full width: single heading
        add_vertex(0, 0, 1'b0);
        add_checked(4095, 0, 4'd1, 4'd1);
        // several steps sharing one heading still give one change
        add_vertex(4095, 4095, 1'b0);
        add_vertex(2047, 4095, 1'b0);
        add_checked(0, 4095, 4'd1, 4'd1);
        // down, right, up, left loop: zero or six by end displacement
        add_vertex(100, 100, 1'b0);
        add_vertex(100, 300, 1'b0);
        add_vertex(300, 300, 1'b0);
        add_vertex(300, 120, 1'b0);
        add_vertex(110, 130, 1'b1);
        // five changes is past what the tree knows
        add_vertex(0, 0, 1'b0);
        add_vertex(10, 0, 1'b0);
        add_vertex(10, 10, 1'b0);
        add_vertex(20, 10, 1'b0);
        add_vertex(20, 20, 1'b0);
        add_checked(30, 20, NO_MATCH, 4'd5);
        // smoothing switched on in the middle of a stroke
        add_vertex(2000, 2000, 1'b0);
        add_vertex(2000, 4095, 1'b0);
        add_setting(ROW_SET_SMOOTHING, 4'd1);
        add_vertex(0, 4095, 1'b1);
        // smoothed corner-to-corner stroke
        add_vertex(4095, 4095, 1'b0);
        add_vertex(0, 0, 1'b1);
        add_setting(ROW_SET_SMOOTHING, 4'd0);

        foreach (script_rows[i]) begin
            row = script_rows[i];
            case (row.kind)
                ROW_VERTEX: send_vertex(row.vertex, row.fixed, row.want);
                ROW_SET_SMOOTHING: begin
                    drain_pipeline();
                    write_register(REG_SMOOTHING, {28'b0, row.value});
                end
                default: begin
                    drain_pipeline();
                    write_register(REG_ZERO_SIX, {28'b0, row.value});
                end
            endcase
        end

        // Random phases, each under its own register setting
        for (int p = 1; p <= PHASE_COUNT; p++) begin
            drain_pipeline();
            case (p)
                1: begin
                    write_register(REG_SMOOTHING, 32'd0);
                    write_register(REG_ZERO_SIX, 32'd0);
                end
                2: begin
                    write_register(REG_SMOOTHING, 32'd1);
                    write_register(REG_ZERO_SIX, 32'd15);
                end
                3: begin
                    write_register(REG_SMOOTHING, 32'd0);
                    write_register(REG_ZERO_SIX, 32'd15);
                end
                4: begin
                    write_register(REG_SMOOTHING, 32'd1);
                    write_register(REG_ZERO_SIX, 32'($urandom_range(1, 14)));
                end
                default: begin
                    write_register(REG_SMOOTHING, 32'd0);
                    write_register(REG_ZERO_SIX, 32'd4);
                end
            endcase
            phase_sent = 0;
            phase_no   = p;
            steady     = (p == 3);
            while (phase_sent < VERTS_PER_PHASE)
                send_random_stroke();
        end

        drain_pipeline();
        steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d strokes from %0d vertices over %0d register writes.",
                 strokes_checked, vertices_sent, register_writes);
        $display("Digit codes seen (bit 10 = no match): %b, mismatches: %0d",
                 digits_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
